// ===== hdl/arpr_pkg.sv =====
// Package for the ARP resolver: codes, register map, stored-word layout and
// the structs passed between the controller, output buffer and register block.
// No dependencies.
`default_nettype none
package arpr_pkg;

    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // Register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_OWN_MAC      = 2'd0;
    localparam logic [1:0] REG_OWN_IP       = 2'd1;
    localparam logic [1:0] REG_ENTRY_TTL    = 2'd2;
    localparam logic [1:0] REG_REQ_HOLDOFF  = 2'd3;

    localparam logic [15:0] DEFAULT_TTL     = 16'd30000;
    localparam logic [15:0] DEFAULT_HOLDOFF = 16'd5000;
    localparam logic [47:0] BCAST_MAC       = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RECV = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] FT_IPV4 = 2'd0;
    localparam logic [1:0] FT_ARP  = 2'd1;

    localparam logic ARP_REQUEST = 1'b0;

    localparam logic [2:0] KIND_IPV4    = 3'd0;
    localparam logic [2:0] KIND_ARP_REQ = 3'd1;
    localparam logic [2:0] KIND_ARP_REP = 3'd2;
    localparam logic [2:0] KIND_DELIVER = 3'd3;
    localparam logic [2:0] KIND_DROP    = 3'd4;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [15:0] entry_ttl_ms;
        logic [15:0] request_holdoff_ms;
    } t_cfg;

    // One memory word: cache {ip, mac, ttl}, request {ip, -, age},
    // pending {ip, -, handle}.
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] low;
    } t_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] dst_mac;
        logic [31:0] tgt_ip;
        logic [15:0] datagram_id_res;
    } t_result;

    typedef struct packed {
        logic    produce;
        logic    finish;
        t_result res;
    } t_emit;

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_CEX, S_CUPD, S_RRD, S_REX, S_RUPD,
        S_QRD, S_QEX, S_QEND, S_TCRD, S_TCEX, S_TRRD, S_TREX, S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/arpr_if.sv =====
// Handshake channels of the ARP resolver: input word and result word.
// No dependencies.
`default_nettype none
interface arpr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] next_hop_ip;
    logic [15:0] datagram_id;
    logic [47:0] frame_dst_mac;
    logic [1:0]  frame_type;
    logic        payload_ok;
    logic        arp_opcode;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_tgt_ip;
    logic [15:0] elapsed_ms;

    modport source (output valid, command, next_hop_ip, datagram_id, frame_dst_mac,
                    frame_type, payload_ok, arp_opcode, arp_sender_ip, arp_sender_mac,
                    arp_tgt_ip, elapsed_ms, input ready);
    modport sink (input valid, command, next_hop_ip, datagram_id, frame_dst_mac,
                  frame_type, payload_ok, arp_opcode, arp_sender_ip, arp_sender_mac,
                  arp_tgt_ip, elapsed_ms, output ready);
endinterface

interface arpr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [31:0] tgt_ip;
    logic [15:0] datagram_id_res;
    logic        last;

    modport source (output valid, kind, dst_mac, tgt_ip, datagram_id_res, last,
                    input ready);
    modport sink (input valid, kind, dst_mac, tgt_ip, datagram_id_res, last,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/arpr_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module arpr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/arpr_cfg.sv =====
// APB-style register block holding own MAC, own IP and the two lifetimes.
// Depends on arpr_pkg.
`default_nettype none
module arpr_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [arpr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [arpr_pkg::DATA_W-1:0] pwdata,
    output logic      [arpr_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output arpr_pkg::t_cfg                   o_cfg
);
    import arpr_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        prdata = '0;
        case (paddr[4:3])
            REG_OWN_MAC: begin
                prdata = {16'd0, r_cfg.own_mac};
                if (wr) begin
                    n_cfg.own_mac = pwdata[47:0];
                end
            end
            REG_OWN_IP: begin
                prdata = {32'd0, r_cfg.own_ip};
                if (wr) begin
                    n_cfg.own_ip = pwdata[31:0];
                end
            end
            REG_ENTRY_TTL: begin
                prdata = {48'd0, r_cfg.entry_ttl_ms};
                if (wr) begin
                    n_cfg.entry_ttl_ms = pwdata[15:0];
                end
            end
            REG_REQ_HOLDOFF: begin
                prdata = {48'd0, r_cfg.request_holdoff_ms};
                if (wr) begin
                    n_cfg.request_holdoff_ms = pwdata[15:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{own_mac: '0, own_ip: '0, entry_ttl_ms: DEFAULT_TTL,
                       request_holdoff_ms: DEFAULT_HOLDOFF};
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/arpr_outbuf.sv =====
// Result staging: holds the newest result until the next one or the end of
// the input word is known, which sets the last flag; then an output register.
// Depends on arpr_pkg and arpr_if.
`default_nettype none
module arpr_outbuf (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  arpr_pkg::t_emit    i_emit,
    output logic               o_ok,
    arpr_out_if.source         o_out
);
    import arpr_pkg::*;

    logic    r_hold_v, n_hold_v;
    t_result r_hold, n_hold;
    logic    r_ov, n_ov;
    t_result r_out, n_out;
    logic    r_last, n_last;

    assign o_ok = !r_hold_v || !r_ov || o_out.ready;

    always_comb begin
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_ov     = r_ov;
        n_out    = r_out;
        n_last   = r_last;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        if (i_emit.produce) begin
            if (r_hold_v) begin
                n_ov   = 1'b1;
                n_out  = r_hold;
                n_last = 1'b0;
            end
            n_hold   = i_emit.res;
            n_hold_v = 1'b1;
        end else if (i_emit.finish && r_hold_v) begin
            n_ov     = 1'b1;
            n_out    = r_hold;
            n_last   = 1'b1;
            n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
        r_last <= n_last;
    end

    assign o_out.valid           = r_ov;
    assign o_out.kind            = r_out.kind;
    assign o_out.dst_mac         = r_out.dst_mac;
    assign o_out.tgt_ip          = r_out.tgt_ip;
    assign o_out.datagram_id_res = r_out.datagram_id_res;
    assign o_out.last            = r_last;
endmodule
`default_nettype wire

// ===== hdl/arp_resolver_with_pending_queue_core.sv =====
// ARP resolver with a queue of datagrams awaiting resolution. The cache, the
// request table and the pending queue share one RAM with a registered read;
// the controller visits entries one at a time, first reading an entry, then
// examining it and writing it back. A send that misses while the queue is
// full puts out a drop. Results leave through an output register, so a
// stalled sink only holds the block when a further result is due.
// Depends on arpr_pkg, arpr_if, arpr_ram, arpr_cfg and arpr_outbuf.
`default_nettype none
module arp_resolver_with_pending_queue_core #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int REQUEST_ENTRIES = 16,
    parameter int PENDING_DEPTH   = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [arpr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [arpr_pkg::DATA_W-1:0] pwdata,
    output logic      [arpr_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    arpr_in_if.sink                          i_in,
    arpr_out_if.source                       o_out
);
    import arpr_pkg::*;

    localparam int C     = CACHE_ENTRIES;
    localparam int R     = REQUEST_ENTRIES;
    localparam int P     = PENDING_DEPTH;
    localparam int CW    = (C > 1) ? $clog2(C) : 1;
    localparam int RW    = (R > 1) ? $clog2(R) : 1;
    localparam int MAXCR = (C > R) ? C : R;
    localparam int MAXE  = (MAXCR > P) ? MAXCR : P;
    localparam int IW    = $clog2(MAXE + 1);
    localparam int PCW   = $clog2(P + 1);
    localparam int DEPTH = C + R + P;
    localparam int AW    = $clog2(DEPTH);
    localparam int RBASE = C;
    localparam int PBASE = C + R;

    t_cfg   cfg;
    t_emit  emit;
    logic   ok;

    t_state r_state, n_state;
    logic [IW-1:0]  r_idx, n_idx;
    logic [RW-1:0]  r_ridx, n_ridx;
    logic [PCW-1:0] r_pcnt, n_pcnt, r_wptr, n_wptr;
    logic [C-1:0]   r_cv, n_cv;
    logic [R-1:0]   r_rv, n_rv;
    logic           r_learn, n_learn;
    logic [31:0]    r_ip, n_ip;
    logic [15:0]    r_id, n_id;
    logic [47:0]    r_mac, n_mac;
    logic           r_reply, n_reply;
    logic [15:0]    r_el, n_el;
    logic           r_hit, n_hit;
    logic [CW-1:0]  r_hit_idx, n_hit_idx;
    logic [47:0]    r_hit_mac, n_hit_mac;
    logic [CW-1:0]  r_min_idx, n_min_idx;
    logic [15:0]    r_min_ttl, n_min_ttl;
    logic           r_rmatch, n_rmatch;
    logic [RW-1:0]  r_max_idx, n_max_idx;
    logic [15:0]    r_max_age, n_max_age;
    logic           r_drop, n_drop;
    logic [31:0]    r_qip, n_qip;
    logic           r_qemit, n_qemit;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    t_word          wdata, rd;
    logic [$bits(t_word)-1:0] ram_rdata;

    logic           c_free, r_free;
    logic [CW-1:0]  c_free_idx, c_slot, ci;
    logic [RW-1:0]  r_free_idx, c_rslot, ri;
    logic [16:0]    c_sum;

    arpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    arpr_ram #(.WIDTH($bits(t_word)), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    arpr_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_ok    (ok),
        .o_out   (o_out)
    );

    assign rd = ram_rdata;
    assign ci = r_idx[CW-1:0];
    assign ri = r_idx[RW-1:0];
    assign i_in.ready = (r_state == S_IDLE);
    assign c_sum = {1'b0, rd.low} + {1'b0, r_el};

    // Lowest free slots of the two tables
    always_comb begin
        c_free = 1'b0;
        c_free_idx = '0;
        for (int i = C - 1; i >= 0; i--) begin
            if (!r_cv[i]) begin
                c_free = 1'b1;
                c_free_idx = CW'(i);
            end
        end
        r_free = 1'b0;
        r_free_idx = '0;
        for (int i = R - 1; i >= 0; i--) begin
            if (!r_rv[i]) begin
                r_free = 1'b1;
                r_free_idx = RW'(i);
            end
        end
    end

    // A learned address reuses its own entry, else a free one, else the one
    // closest to expiry; a new request takes a free entry, else the oldest.
    assign c_slot  = r_hit ? r_hit_idx : (c_free ? c_free_idx : r_min_idx);
    assign c_rslot = r_free ? r_free_idx : r_max_idx;

    always_comb begin
        case (r_state)
            S_CRD, S_CEX, S_TCRD, S_TCEX: raddr = AW'(r_idx);
            S_RRD, S_REX:                 raddr = AW'(RBASE) + AW'(r_idx);
            S_TRRD, S_TREX:               raddr = AW'(RBASE) + AW'(r_ridx);
            S_QRD, S_QEX:                 raddr = AW'(PBASE) + AW'(r_idx);
            default:                      raddr = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_ridx    = r_ridx;
        n_pcnt    = r_pcnt;
        n_wptr    = r_wptr;
        n_cv      = r_cv;
        n_rv      = r_rv;
        n_learn   = r_learn;
        n_ip      = r_ip;
        n_id      = r_id;
        n_mac     = r_mac;
        n_reply   = r_reply;
        n_el      = r_el;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_hit_mac = r_hit_mac;
        n_min_idx = r_min_idx;
        n_min_ttl = r_min_ttl;
        n_rmatch  = r_rmatch;
        n_max_idx = r_max_idx;
        n_max_age = r_max_age;
        n_drop    = r_drop;
        n_qip     = r_qip;
        n_qemit   = r_qemit;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        emit      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_idx = '0;
                    n_hit = 1'b0;
                    case (i_in.command)
                        CMD_SEND: begin
                            n_ip    = i_in.next_hop_ip;
                            n_id    = i_in.datagram_id;
                            n_learn = 1'b0;
                            n_state = S_CRD;
                        end
                        CMD_RECV: begin
                            if ((i_in.frame_dst_mac == cfg.own_mac ||
                                 i_in.frame_dst_mac == BCAST_MAC) &&
                                i_in.payload_ok) begin
                                if (i_in.frame_type == FT_IPV4) begin
                                    emit.produce = 1'b1;
                                    emit.res = '{kind: KIND_DELIVER, dst_mac: '0,
                                                 tgt_ip: '0,
                                                 datagram_id_res: i_in.datagram_id};
                                    n_state = S_DONE;
                                end else if (i_in.frame_type == FT_ARP) begin
                                    n_ip    = i_in.arp_sender_ip;
                                    n_mac   = i_in.arp_sender_mac;
                                    n_reply = (i_in.arp_opcode == ARP_REQUEST) &&
                                              (i_in.arp_tgt_ip == cfg.own_ip);
                                    n_learn = 1'b1;
                                    n_state = S_CRD;
                                end
                            end
                        end
                        CMD_TICK: begin
                            n_el    = i_in.elapsed_ms;
                            n_state = S_TCRD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CRD: begin
                n_state = S_CEX;
            end
            S_CEX: begin
                if (r_cv[ci] && rd.ip == r_ip && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = ci;
                    n_hit_mac = rd.mac;
                end
                if (r_idx == '0 || rd.low < r_min_ttl) begin
                    n_min_idx = ci;
                    n_min_ttl = rd.low;
                end
                if (r_idx == IW'(C - 1)) begin
                    n_state = S_CUPD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_CRD;
                end
            end
            S_CUPD: begin
                if (!r_learn) begin
                    if (r_hit) begin
                        if (ok) begin
                            emit.produce = 1'b1;
                            emit.res = '{kind: KIND_IPV4, dst_mac: r_hit_mac,
                                         tgt_ip: r_ip, datagram_id_res: r_id};
                            n_state = S_DONE;
                        end
                    end else begin
                        if (r_pcnt != PCW'(P)) begin
                            we     = 1'b1;
                            waddr  = AW'(PBASE) + AW'(r_pcnt);
                            wdata  = '{ip: r_ip, mac: '0, low: r_id};
                            n_pcnt = r_pcnt + PCW'(1);
                            n_drop = 1'b0;
                        end else begin
                            n_drop = 1'b1;
                        end
                        n_idx    = '0;
                        n_rmatch = 1'b0;
                        n_state  = S_RRD;
                    end
                end else begin
                    we            = 1'b1;
                    waddr         = AW'(c_slot);
                    wdata         = '{ip: r_ip, mac: r_mac, low: cfg.entry_ttl_ms};
                    n_cv[c_slot]  = 1'b1;
                    n_qip         = r_ip;
                    n_qemit       = 1'b1;
                    n_idx         = '0;
                    n_wptr        = '0;
                    n_state       = S_QRD;
                end
            end
            S_RRD: begin
                n_state = S_REX;
            end
            S_REX: begin
                if (r_rv[ri] && rd.ip == r_ip) begin
                    n_rmatch = 1'b1;
                end
                if (r_idx == '0 || rd.low > r_max_age) begin
                    n_max_idx = ri;
                    n_max_age = rd.low;
                end
                if (r_idx == IW'(R - 1)) begin
                    n_state = S_RUPD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_RRD;
                end
            end
            S_RUPD: begin
                // A drop for a full queue goes out before the request broadcast
                if (ok) begin
                    if (r_drop) begin
                        emit.produce = 1'b1;
                        emit.res = '{kind: KIND_DROP, dst_mac: '0, tgt_ip: r_ip,
                                     datagram_id_res: r_id};
                        n_drop = 1'b0;
                    end else if (!r_rmatch) begin
                        we            = 1'b1;
                        waddr         = AW'(RBASE) + AW'(c_rslot);
                        wdata         = '{ip: r_ip, mac: '0, low: '0};
                        n_rv[c_rslot] = 1'b1;
                        emit.produce  = 1'b1;
                        emit.res = '{kind: KIND_ARP_REQ, dst_mac: BCAST_MAC,
                                     tgt_ip: r_ip, datagram_id_res: '0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_QRD: begin
                if (r_idx == IW'(r_pcnt)) begin
                    n_state = S_QEND;
                end else begin
                    n_state = S_QEX;
                end
            end
            S_QEX: begin
                // Compact the queue in place: kept words move down to r_wptr.
                if (rd.ip == r_qip) begin
                    if (!r_qemit || ok) begin
                        if (r_qemit) begin
                            emit.produce = 1'b1;
                            emit.res = '{kind: KIND_IPV4, dst_mac: r_mac,
                                         tgt_ip: r_qip, datagram_id_res: rd.low};
                        end
                        n_idx   = r_idx + IW'(1);
                        n_state = S_QRD;
                    end
                end else begin
                    we      = 1'b1;
                    waddr   = AW'(PBASE) + AW'(r_wptr);
                    wdata   = rd;
                    n_wptr  = r_wptr + PCW'(1);
                    n_idx   = r_idx + IW'(1);
                    n_state = S_QRD;
                end
            end
            S_QEND: begin
                n_pcnt = r_wptr;
                if (r_qemit) begin
                    if (r_reply) begin
                        if (ok) begin
                            emit.produce = 1'b1;
                            emit.res = '{kind: KIND_ARP_REP, dst_mac: r_mac,
                                         tgt_ip: r_ip, datagram_id_res: '0};
                            n_state = S_DONE;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_ridx == RW'(R - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_ridx  = r_ridx + RW'(1);
                    n_state = S_TRRD;
                end
            end
            S_TCRD: begin
                n_state = S_TCEX;
            end
            S_TCEX: begin
                if (r_cv[ci]) begin
                    if (rd.low <= r_el) begin
                        n_cv[ci] = 1'b0;
                    end else begin
                        we    = 1'b1;
                        waddr = AW'(r_idx);
                        wdata = '{ip: rd.ip, mac: rd.mac, low: rd.low - r_el};
                    end
                end
                if (r_idx == IW'(C - 1)) begin
                    n_ridx  = '0;
                    n_state = S_TRRD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_TCRD;
                end
            end
            S_TRRD: begin
                n_state = S_TREX;
            end
            S_TREX: begin
                if (r_rv[r_ridx] && c_sum >= {1'b0, cfg.request_holdoff_ms}) begin
                    // Expired: purge its datagrams, then carry on with the table
                    n_rv[r_ridx] = 1'b0;
                    n_qip        = rd.ip;
                    n_qemit      = 1'b0;
                    n_idx        = '0;
                    n_wptr       = '0;
                    n_state      = S_QRD;
                end else begin
                    if (r_rv[r_ridx]) begin
                        we    = 1'b1;
                        waddr = AW'(RBASE) + AW'(r_ridx);
                        wdata = '{ip: rd.ip, mac: rd.mac, low: c_sum[15:0]};
                    end
                    if (r_ridx == RW'(R - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_ridx  = r_ridx + RW'(1);
                        n_state = S_TRRD;
                    end
                end
            end
            S_DONE: begin
                if (ok) begin
                    emit.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cv    <= '0;
            r_rv    <= '0;
            r_pcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_cv    <= n_cv;
            r_rv    <= n_rv;
            r_pcnt  <= n_pcnt;
        end
        r_idx     <= n_idx;
        r_ridx    <= n_ridx;
        r_wptr    <= n_wptr;
        r_learn   <= n_learn;
        r_ip      <= n_ip;
        r_id      <= n_id;
        r_mac     <= n_mac;
        r_reply   <= n_reply;
        r_el      <= n_el;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_hit_mac <= n_hit_mac;
        r_min_idx <= n_min_idx;
        r_min_ttl <= n_min_ttl;
        r_rmatch  <= n_rmatch;
        r_max_idx <= n_max_idx;
        r_max_age <= n_max_age;
        r_drop    <= n_drop;
        r_qip     <= n_qip;
        r_qemit   <= n_qemit;
    end
endmodule
`default_nettype wire
